>>> rtl/cbm_pkg.sv
// Shared types and constants of the color blend mode mixer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cbm_pkg;

    localparam int MODE_BITS  = 4;
    localparam int NUM_LANES  = 5;
    localparam int NUM_STAGES = 5;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_MIX        = 4'd0,
        MODE_ADD        = 4'd1,
        MODE_MULTIPLY   = 4'd2,
        MODE_SUBTRACT   = 4'd3,
        MODE_SCREEN     = 4'd4,
        MODE_DIFFERENCE = 4'd5,
        MODE_DARKEN     = 4'd6,
        MODE_LIGHTEN    = 4'd7,
        MODE_OVERLAY    = 4'd8
    } mode_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] full;
    } ctrl_t;

endpackage

`default_nettype wire

>>> rtl/cbm_item_if.sv
// Input channel of the mixer: valid/ready handshake and the two colors,
// two scalars and the blend factor. No dependencies.
`default_nettype none

interface cbm_item_if #(
    parameter int VALUE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] in1_red;
    logic signed [VALUE_WIDTH-1:0] in1_green;
    logic signed [VALUE_WIDTH-1:0] in1_blue;
    logic signed [VALUE_WIDTH-1:0] in1_alpha;
    logic signed [VALUE_WIDTH-1:0] in1_scalar;
    logic signed [VALUE_WIDTH-1:0] in2_red;
    logic signed [VALUE_WIDTH-1:0] in2_green;
    logic signed [VALUE_WIDTH-1:0] in2_blue;
    logic signed [VALUE_WIDTH-1:0] in2_alpha;
    logic signed [VALUE_WIDTH-1:0] in2_scalar;
    logic signed [VALUE_WIDTH-1:0] blend_factor;

    modport source (
        output valid, in1_red, in1_green, in1_blue, in1_alpha, in1_scalar,
        output in2_red, in2_green, in2_blue, in2_alpha, in2_scalar, blend_factor,
        input  ready
    );

    modport sink (
        input  valid, in1_red, in1_green, in1_blue, in1_alpha, in1_scalar,
        input  in2_red, in2_green, in2_blue, in2_alpha, in2_scalar, blend_factor,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/cbm_result_if.sv
// Output channel of the mixer: valid/ready handshake and the blended
// color and scalar. No dependencies.
`default_nettype none

interface cbm_result_if #(
    parameter int VALUE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] out_red;
    logic signed [VALUE_WIDTH-1:0] out_green;
    logic signed [VALUE_WIDTH-1:0] out_blue;
    logic signed [VALUE_WIDTH-1:0] out_alpha;
    logic signed [VALUE_WIDTH-1:0] out_scalar;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha, out_scalar,
        input  ready
    );

    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha, out_scalar,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/cbm_ctrl.sv
// Pipeline flow control: per-stage occupancy and load enables.
// Depends on cbm_pkg.
`default_nettype none

module cbm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           out_ready,
    output logic           in_ready,
    output logic           out_valid,
    output cbm_pkg::ctrl_t ctrl
);
    import cbm_pkg::*;

    logic [NUM_STAGES-1:0] full_reg;
    logic [NUM_STAGES-1:0] full_next;
    logic [NUM_STAGES-1:0] load;

    // a stage loads when empty or when the stage after it loads
    always_comb
    begin
        load[NUM_STAGES-1] = !full_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            load[k] = !full_reg[k] || load[k+1];
        end
    end

    always_comb
    begin
        full_next = full_reg;
        if (load[0])
        begin
            full_next[0] = in_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (load[k])
            begin
                full_next[k] = full_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= '0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    assign in_ready  = load[0];
    assign out_valid = full_reg[NUM_STAGES-1];
    assign ctrl.load = load;
    assign ctrl.full = full_reg;

endmodule

`default_nettype wire

>>> rtl/cbm_lane.sv
// One blend lane: operand prep, first product, combine, second product,
// and rounding of the second product. Depends on cbm_pkg.
`default_nettype none

module cbm_lane #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                          clk,
    input  cbm_pkg::mode_t                mode,
    input  cbm_pkg::ctrl_t                ctrl,
    input  logic signed [VALUE_WIDTH-1:0] a,
    input  logic signed [VALUE_WIDTH-1:0] b,
    input  logic signed [VALUE_WIDTH-1:0] f2,
    output logic signed [VALUE_WIDTH+1:0] value
);
    import cbm_pkg::*;

    localparam int IW = VALUE_WIDTH + 2;
    localparam int FB = VALUE_WIDTH - 4;
    localparam int PW = 2 * IW;
    localparam int SW = PW - FB;

    localparam logic signed [IW-1:0] I_MAX  = {1'b0, {(IW-1){1'b1}}};
    localparam logic signed [IW-1:0] I_MIN  = {1'b1, {(IW-1){1'b0}}};
    localparam logic signed [IW-1:0] ONE    = {{(IW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
    localparam logic signed [IW-1:0] HALF_Q = {{(IW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
    localparam logic signed [PW-1:0] HALF_P = {{(PW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};

    function automatic logic signed [IW-1:0] sat_w(input logic signed [IW:0] v);
        if (v > (IW+1)'(I_MAX))
        begin
            return I_MAX;
        end
        if (v < (IW+1)'(I_MIN))
        begin
            return I_MIN;
        end
        return v[IW-1:0];
    endfunction

    // round to nearest, ties away from zero, then saturate
    function automatic logic signed [IW-1:0] qround(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        logic signed [SW-1:0] sh;
        s  = p + HALF_P - $signed({{(PW-1){1'b0}}, p[PW-1]});
        sh = s[PW-1:FB];
        if (sh > SW'(I_MAX))
        begin
            return I_MAX;
        end
        if (sh < SW'(I_MIN))
        begin
            return I_MIN;
        end
        return sh[IW-1:0];
    endfunction

    // stage 0: operand prep
    logic signed [IW-1:0] a_x, b_x, f2_x, f1_c, omb_c, dif_c, abs_c, x_c, y_c;
    logic signed [IW-1:0] a0_reg, f10_reg, x0_reg, y0_reg;

    always_comb
    begin
        a_x   = IW'(a);
        b_x   = IW'(b);
        f2_x  = IW'(f2);
        f1_c  = ONE - f2_x;
        omb_c = ONE - b_x;
        dif_c = a_x - b_x;
        abs_c = dif_c[IW-1] ? -dif_c : dif_c;
        x_c   = (mode == MODE_OVERLAY) ? (f2_x <<< 1) : f2_x;
        unique case (mode)
            MODE_DIFFERENCE: y_c = abs_c;
            MODE_SCREEN:     y_c = omb_c;
            MODE_OVERLAY:    y_c = (a_x < HALF_Q) ? b_x : omb_c;
            default:         y_c = b_x;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            a0_reg  <= a_x;
            f10_reg <= f1_c;
            x0_reg  <= x_c;
            y0_reg  <= y_c;
        end
    end

    // stage 1: first products
    logic signed [IW-1:0] a1_reg, f11_reg;
    logic signed [PW-1:0] p0_reg, p1_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            a1_reg  <= a0_reg;
            f11_reg <= f10_reg;
            p0_reg  <= PW'(f10_reg) * PW'(a0_reg);
            p1_reg  <= PW'(x0_reg) * PW'(y0_reg);
        end
    end

    // stage 2: round and combine
    logic signed [IW-1:0] q0_c, q1_c, res_c, t_c, z_c, fac_c, oma_c;
    logic                 use2_c, inv_c, alow_c;
    logic signed [IW-1:0] res2_reg, t2_reg, z2_reg;
    logic                 use2_2_reg, inv2_reg;

    always_comb
    begin
        q0_c   = qround(p0_reg);
        q1_c   = qround(p1_reg);
        fac_c  = sat_w((IW+1)'(f11_reg) + (IW+1)'(q1_c));
        oma_c  = ONE - a1_reg;
        alow_c = a1_reg < HALF_Q;
        res_c  = '0;
        t_c    = fac_c;
        z_c    = a1_reg;
        use2_c = 1'b0;
        inv_c  = 1'b0;
        unique case (mode)
            MODE_ADD:      res_c = sat_w((IW+1)'(a1_reg) + (IW+1)'(q1_c));
            MODE_SUBTRACT: res_c = sat_w((IW+1)'(a1_reg) - (IW+1)'(q1_c));
            MODE_MULTIPLY: use2_c = 1'b1;
            MODE_SCREEN:
            begin
                z_c    = oma_c;
                use2_c = 1'b1;
                inv_c  = 1'b1;
            end
            MODE_DARKEN:   res_c = (q1_c < a1_reg) ? q1_c : a1_reg;
            MODE_LIGHTEN:  res_c = (q1_c > a1_reg) ? q1_c : a1_reg;
            MODE_OVERLAY:
            begin
                z_c    = alow_c ? a1_reg : oma_c;
                use2_c = 1'b1;
                inv_c  = !alow_c;
            end
            default:       res_c = sat_w((IW+1)'(q0_c) + (IW+1)'(q1_c));
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            res2_reg   <= res_c;
            t2_reg     <= t_c;
            z2_reg     <= z_c;
            use2_2_reg <= use2_c;
            inv2_reg   <= inv_c;
        end
    end

    // stage 3: second product
    logic signed [PW-1:0] p3_reg;
    logic signed [IW-1:0] res3_reg;
    logic                 use2_3_reg, inv3_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
        begin
            p3_reg     <= PW'(t2_reg) * PW'(z2_reg);
            res3_reg   <= res2_reg;
            use2_3_reg <= use2_2_reg;
            inv3_reg   <= inv2_reg;
        end
    end

    logic signed [IW-1:0] q2_c;

    always_comb
    begin
        q2_c = qround(p3_reg);
        if (!use2_3_reg)
        begin
            value = res3_reg;
        end
        else if (inv3_reg)
        begin
            value = sat_w((IW+1)'(ONE) - (IW+1)'(q2_c));
        end
        else
        begin
            value = q2_c;
        end
    end

endmodule

`default_nettype wire

>>> rtl/cbm_merge.sv
// Output stage: saturates every lane to the field width and registers
// the full result transaction. Depends on cbm_pkg.
`default_nettype none

module cbm_merge #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                                          clk,
    input  cbm_pkg::ctrl_t                                ctrl,
    input  logic [cbm_pkg::NUM_LANES-1:0][VALUE_WIDTH+1:0] lane_value,
    output logic [cbm_pkg::NUM_LANES-1:0][VALUE_WIDTH-1:0] mixed
);
    import cbm_pkg::*;

    localparam int IW = VALUE_WIDTH + 2;
    localparam logic signed [VALUE_WIDTH-1:0] O_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] O_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    function automatic logic [VALUE_WIDTH-1:0] sat_out(input logic signed [IW-1:0] v);
        if (v > IW'(O_MAX))
        begin
            return O_MAX;
        end
        if (v < IW'(O_MIN))
        begin
            return O_MIN;
        end
        return v[VALUE_WIDTH-1:0];
    endfunction

    logic [NUM_LANES-1:0][VALUE_WIDTH-1:0] mixed_reg;
    logic [NUM_LANES-1:0][VALUE_WIDTH-1:0] mixed_next;

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            mixed_next[i] = sat_out($signed(lane_value[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[NUM_STAGES-1])
        begin
            mixed_reg <= mixed_next;
        end
    end

    assign mixed = mixed_reg;

endmodule

`default_nettype wire

>>> rtl/color_blend_mode_mixer_top.sv
// Top level of the color blend mode mixer: mode register, flow control,
// five blend lanes and the output stage.
// Depends on cbm_pkg, cbm_item_if, cbm_result_if, cbm_ctrl, cbm_lane, cbm_merge.
//
// Usage:
//   item   - input transactions: two RGBA colors, two scalars, blend factor.
//   result - output transactions: one blended RGBA color and scalar.
//   wr_en/wr_data - blend mode register; write only while no transaction
//   is in flight. Codes above overlay blend as mix.
// Red, green, blue, alpha and scalar each run in a lane of their own.
// An accepted item passes through five registered stages in order: operand
// prep, first product, combine, second product and the saturating output
// register.
// Throughput: one transaction per cycle while result is ready.
// A stalled result holds; empty stages still fill, so item.ready drops only
// once all five stages hold transactions.
// Reset clears all stage occupancy and sets the mode to mix.
`default_nettype none

module color_blend_mode_mixer_top #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    cbm_item_if.sink                          item,
    cbm_result_if.source                      result,
    input  logic                              wr_en,
    input  logic [cbm_pkg::MODE_BITS-1:0]     wr_data
);
    import cbm_pkg::*;

    mode_t mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_MIX;
        end
        else if (wr_en)
        begin
            mode_reg <= mode_t'(wr_data);
        end
    end

    ctrl_t ctrl;

    cbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .out_ready (result.ready),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .ctrl      (ctrl)
    );

    logic [NUM_LANES-1:0][VALUE_WIDTH-1:0] lane_a;
    logic [NUM_LANES-1:0][VALUE_WIDTH-1:0] lane_b;
    logic [NUM_LANES-1:0][VALUE_WIDTH+1:0] lane_value;
    logic [NUM_LANES-1:0][VALUE_WIDTH-1:0] mixed;

    assign lane_a[0] = item.in1_red;
    assign lane_a[1] = item.in1_green;
    assign lane_a[2] = item.in1_blue;
    assign lane_a[3] = item.in1_alpha;
    assign lane_a[4] = item.in1_scalar;
    assign lane_b[0] = item.in2_red;
    assign lane_b[1] = item.in2_green;
    assign lane_b[2] = item.in2_blue;
    assign lane_b[3] = item.in2_alpha;
    assign lane_b[4] = item.in2_scalar;

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        cbm_lane #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_lane (
            .clk   (clk),
            .mode  (mode_reg),
            .ctrl  (ctrl),
            .a     ($signed(lane_a[i])),
            .b     ($signed(lane_b[i])),
            .f2    (item.blend_factor),
            .value (lane_value[i])
        );
    end

    cbm_merge #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_merge (
        .clk        (clk),
        .ctrl       (ctrl),
        .lane_value (lane_value),
        .mixed      (mixed)
    );

    assign result.out_red    = mixed[0];
    assign result.out_green  = mixed[1];
    assign result.out_blue   = mixed[2];
    assign result.out_alpha  = mixed[3];
    assign result.out_scalar = mixed[4];

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> ctrl.full[0])
        else $error("accepted transaction did not enter the first stage");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.ready && !ctrl.full[NUM_STAGES-2] |=> !result.valid)
        else $error("result valid without a transaction behind it");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (&ctrl.full) && !result.ready)
        else $error("input stalled while the pipeline had room");

endmodule

`default_nettype wire

>>> verif/tb_color_blend_mode_mixer_top.sv
// Testbench of color_blend_mode_mixer_top: drives pixel pairs under every blend mode with
// random gaps and stalls, and checks each blended pixel against its own fixed-point predictor.
// Depends on cbm_pkg, cbm_item_if, cbm_result_if and the mixer RTL.
`default_nettype none

module tb_color_blend_mode_mixer_top;
    import cbm_pkg::*;

    localparam int VW          = 16;
    localparam int FRAC        = VW - 4;
    localparam int LANES       = 5;
    localparam int LATENCY     = 5;
    localparam int IDLE_LIMIT  = 4000;
    localparam int PHASES      = 20;
    localparam int PHASE_ITEMS = 100;
    localparam int MAX_REPORTS = 10;
    localparam logic [MODE_BITS-1:0] SPARE_CODE_LOW = 4'd9;
    localparam logic [MODE_BITS-1:0] SPARE_CODE_TOP = 4'd15;

    typedef struct packed {
        logic [LANES-1:0][VW-1:0] color_a;
        logic [LANES-1:0][VW-1:0] color_b;
        logic [VW-1:0]            factor;
    } pixel_pair_t;

    typedef logic [LANES-1:0][VW-1:0] blended_t;

    class blend_scoreboard;
        logic [MODE_BITS-1:0] mode;
        blended_t             blended_q[$];
        int                   mismatches;

        function new();
            mode       = MODE_MIX;
            mismatches = 0;
        endfunction

        function longint clamp_wide(longint v);
            longint lim;
            lim = longint'(1) <<< (VW + 1);
            if (v > lim - 1)
                return lim - 1;
            if (v < -lim)
                return -lim;
            return v;
        endfunction

        function longint rounded_product(longint a, longint b);
            bit     neg;
            longint ma;
            longint mb;
            longint r;
            longint lim;
            lim = longint'(1) <<< (VW + 1);
            neg = (a < 0) != (b < 0);
            ma  = (a < 0) ? -a : a;
            mb  = (b < 0) ? -b : b;
            r   = (ma * mb + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
            if (neg)
            begin
                if (r > lim)
                    r = lim;
                return -r;
            end
            if (r > lim - 1)
                r = lim - 1;
            return r;
        endfunction

        function longint blend_lane(longint a, longint b, longint f2);
            longint one;
            longint f1;
            longint t;
            longint u;
            one = longint'(1) <<< FRAC;
            f1  = clamp_wide(one - f2);
            case (mode)
                MODE_ADD:
                    return clamp_wide(a + rounded_product(f2, b));
                MODE_MULTIPLY:
                    return rounded_product(a, clamp_wide(f1 + rounded_product(f2, b)));
                MODE_SUBTRACT:
                    return clamp_wide(a - rounded_product(f2, b));
                MODE_SCREEN:
                begin
                    t = clamp_wide(f1 + rounded_product(f2, clamp_wide(one - b)));
                    return clamp_wide(one - rounded_product(t, clamp_wide(one - a)));
                end
                MODE_DIFFERENCE:
                begin
                    t = clamp_wide(a - b);
                    if (t < 0)
                        t = clamp_wide(-t);
                    return clamp_wide(rounded_product(f1, a) + rounded_product(f2, t));
                end
                MODE_DARKEN:
                begin
                    t = rounded_product(f2, b);
                    return (t < a) ? t : a;
                end
                MODE_LIGHTEN:
                begin
                    t = rounded_product(f2, b);
                    return (t > a) ? t : a;
                end
                MODE_OVERLAY:
                begin
                    u = clamp_wide(2 * f2);
                    if (a < (one >>> 1))
                        return rounded_product(a, clamp_wide(f1 + rounded_product(u, b)));
                    t = clamp_wide(f1 + rounded_product(u, clamp_wide(one - b)));
                    return clamp_wide(one - rounded_product(t, clamp_wide(one - a)));
                end
                default:
                    return clamp_wide(rounded_product(f1, a) + rounded_product(f2, b));
            endcase
        endfunction

        function void note_item(pixel_pair_t p);
            blended_t exp;
            longint   r;
            longint   top;
            top = (longint'(1) <<< (VW - 1)) - 1;
            for (int i = 0; i < LANES; i++)
            begin
                r = blend_lane(longint'($signed(p.color_a[i])), longint'($signed(p.color_b[i])),
                               longint'($signed(p.factor)));
                if (r > top)
                    r = top;
                if (r < -top - 1)
                    r = -top - 1;
                exp[i] = r[VW-1:0];
            end
            blended_q = {blended_q, exp};
        endfunction

        function void check_result(blended_t got);
            blended_t exp;
            if (blended_q.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result transaction: %h", got);
                mismatches++;
                return;
            end
            exp = blended_q.pop_front();
            for (int i = 0; i < LANES; i++)
            begin
                if (got[i] !== exp[i])
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("mismatch lane %0d mode %0d: expected %0d, actual %0d",
                                 i, mode, $signed(exp[i]), $signed(got[i]));
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return blended_q.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 wr_en;
    logic [MODE_BITS-1:0] wr_data;
    bit                   tx_quiet;
    bit                   rx_quiet;
    int                   idle_cycles;
    blend_scoreboard      sb;

    cbm_item_if   #(.VALUE_WIDTH(VW)) item ();
    cbm_result_if #(.VALUE_WIDTH(VW)) result ();

    color_blend_mode_mixer_top #(.VALUE_WIDTH(VW)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .result  (result),
        .wr_en   (wr_en),
        .wr_data (wr_data)
    );

    always #5 clk = ~clk;

    function automatic logic [VW-1:0] draw_value();
        int v;
        case ($urandom_range(0, 9))
            0: v = 32767;
            1: v = -32768;
            2: v = int'($urandom_range(0, 16384)) - 8192;
            3:
            begin
                case ($urandom_range(0, 6))
                    0: v = 0;
                    1: v = 4096;
                    2: v = 2048;
                    3: v = 2047;
                    4: v = -4096;
                    5: v = 1;
                    default: v = -1;
                endcase
            end
            default: v = int'($urandom_range(0, 65535));
        endcase
        return v[VW-1:0];
    endfunction

    function automatic pixel_pair_t random_pair();
        pixel_pair_t p;
        int          f;
        for (int i = 0; i < LANES; i++)
        begin
            p.color_a[i] = draw_value();
            p.color_b[i] = draw_value();
        end
        if ($urandom_range(0, 2) != 0)
        begin
            f        = int'($urandom_range(0, 4096));
            p.factor = f[VW-1:0];
        end
        else
            p.factor = draw_value();
        return p;
    endfunction

    function automatic pixel_pair_t uniform_pair(int a, int b, int f);
        pixel_pair_t p;
        for (int i = 0; i < LANES; i++)
        begin
            p.color_a[i] = a[VW-1:0];
            p.color_b[i] = b[VW-1:0];
        end
        p.factor = f[VW-1:0];
        return p;
    endfunction

    task automatic send_pair(pixel_pair_t p);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid        <= 1'b1;
        item.in1_red      <= p.color_a[0];
        item.in1_green    <= p.color_a[1];
        item.in1_blue     <= p.color_a[2];
        item.in1_alpha    <= p.color_a[3];
        item.in1_scalar   <= p.color_a[4];
        item.in2_red      <= p.color_b[0];
        item.in2_green    <= p.color_b[1];
        item.in2_blue     <= p.color_b[2];
        item.in2_alpha    <= p.color_b[3];
        item.in2_scalar   <= p.color_b[4];
        item.blend_factor <= p.factor;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        sb.note_item(p);
    endtask

    task automatic set_blend_mode(logic [MODE_BITS-1:0] m);
        item.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 3) @(posedge clk);
        wr_en   <= 1'b1;
        wr_data <= m;
        @(posedge clk);
        wr_en   <= 1'b0;
        sb.mode = m;
    endtask

    initial
    begin
        blended_t got;
        int       gap;
        @(posedge clk);
        forever
        begin
            gap = rx_quiet ? 0 : $urandom_range(0, 12);
            if (gap > 0)
            begin
                result.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result.ready <= 1'b1;
            @(posedge clk);
            while (!result.valid)
                @(posedge clk);
            got = {result.out_scalar, result.out_alpha, result.out_blue,
                   result.out_green, result.out_red};
            sb.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if ((item.valid && item.ready) || (result.valid && result.ready) || wr_en || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_color_blend_mode_mixer_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        logic [MODE_BITS-1:0] m;
        sb                = new();
        clk               = 1'b0;
        rst_n             = 1'b0;
        wr_en             = 1'b0;
        wr_data           = MODE_MIX;
        tx_quiet          = 1'b0;
        rx_quiet          = 1'b0;
        idle_cycles       = 0;
        item.valid        = 1'b0;
        item.in1_red      = '0;
        item.in1_green    = '0;
        item.in1_blue     = '0;
        item.in1_alpha    = '0;
        item.in1_scalar   = '0;
        item.in2_red      = '0;
        item.in2_green    = '0;
        item.in2_blue     = '0;
        item.in2_alpha    = '0;
        item.in2_scalar   = '0;
        item.blend_factor = '0;
        result.ready      = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = MODE_MIX; k <= MODE_OVERLAY; k++)
        begin
            set_blend_mode(k[MODE_BITS-1:0]);
            send_pair(uniform_pair(32767, -32768, 32767));
            send_pair(uniform_pair(-32768, 32767, -32768));
        end
        send_pair(uniform_pair(2047, 4096, 4096));
        send_pair(uniform_pair(2048, 4096, 4096));
        set_blend_mode(MODE_ADD);
        send_pair(uniform_pair(0, 1, 2048));
        send_pair(uniform_pair(0, -1, 2048));
        set_blend_mode(SPARE_CODE_TOP);
        send_pair(uniform_pair(4096, 0, 4096));
        set_blend_mode(SPARE_CODE_LOW);
        send_pair(uniform_pair(-4096, 8192, 2048));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 0)
                m = MODE_MIX;
            else if (ph == 1)
                m = SPARE_CODE_TOP;
            else if (ph <= 10)
                m = MODE_BITS'(int'(MODE_MIX) + ph - 2);
            else
                m = MODE_BITS'($urandom_range(0, 15));
            set_blend_mode(m);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_pair(random_pair());
        end

        item.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY * 4) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb_color_blend_mode_mixer_top OK");
        else
            $display("tb_color_blend_mode_mixer_top NOT OK");
        $finish;
    end
endmodule

`default_nettype wire

>>> sim.f
rtl/cbm_pkg.sv
rtl/cbm_item_if.sv
rtl/cbm_result_if.sv
rtl/cbm_ctrl.sv
rtl/cbm_lane.sv
rtl/cbm_merge.sv
rtl/color_blend_mode_mixer_top.sv
verif/tb_color_blend_mode_mixer_top.sv
